/* rtl/pflr_pkg.sv */
// ----------------------------------------------------------------------------
// pflr_pkg
// Shared types and constants for the page-mode LCD frame store refresher.
// ----------------------------------------------------------------------------
package pflr_pkg;

    // default geometry
    localparam int DEF_COLUMNS      = 122;
    localparam int DEF_PAGES        = 4;
    localparam int DEF_HALF_COLUMNS = 61;

    // panel command bytes
    localparam logic [7:0] PAGE_CMD_BASE = 8'hB8;
    localparam logic [7:0] COL_ZERO_CMD  = 8'h00;

    // item function codes
    typedef enum logic [1:0] {
        FUNC_DRAW    = 2'd0,
        FUNC_REFRESH = 2'd1,
        FUNC_CLEAR   = 2'd2,
        FUNC_TICK    = 2'd3
    } t_func;

    // input item
    typedef struct packed {
        t_func       func;
        logic [7:0]  x;
        logic [7:0]  y;
        logic        pixel_on;
        logic [7:0]  fill_byte;
    } t_in_item;

    // result item
    typedef struct packed {
        logic        right_chip;
        logic        is_data;
        logic [7:0]  bus_byte;
        logic        last;
    } t_out_item;

endpackage

/* rtl/pflr_store.sv */
// ----------------------------------------------------------------------------
// pflr_store
// Frame store memory, one row per column, with a valid bit per row so that
// rows never written read as zero straight after reset.
// ----------------------------------------------------------------------------
module pflr_store
    import pflr_pkg::*;
#(
    parameter int DEPTH = DEF_COLUMNS,
    parameter int WIDTH = DEF_PAGES * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_row_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    // memory array, registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // row valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    // unwritten rows read as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* rtl/page_framebuffer_lcd_refresher_top.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_lcd_refresher_top
// Monochrome page-mode frame store with draw, refresh and clear sequencing.
// Result path: a tick's result is registered in stage one, then in the result register.
// Throughput: one item per cycle; o_busy is always low, the results cannot
// be stalled, so the store read port and its forwarding path set the rate.
// Reset: synchronous, clears the sequencer and the store row valid bits, so
// the frame store reads as all zero right after reset.
// ----------------------------------------------------------------------------
module page_framebuffer_lcd_refresher_top
    import pflr_pkg::*;
#(
    parameter int COLUMNS      = DEF_COLUMNS,
    parameter int PAGES        = DEF_PAGES,
    parameter int HALF_COLUMNS = DEF_HALF_COLUMNS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int AW       = $clog2(COLUMNS);
    localparam int PW       = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int RW       = PAGES * 8;
    localparam int PER_CHIP = HALF_COLUMNS + 2;
    localparam int PER_PAGE = 2 * PER_CHIP;
    localparam int SW       = $clog2(PER_PAGE);

    // sequencer state
    logic          r_seq_active, n_seq_active;
    logic          r_seq_is_clear, n_seq_is_clear;
    logic [PW-1:0] r_seq_page, n_seq_page;
    logic [SW-1:0] r_seq_step, n_seq_step;
    logic [7:0]    r_held_fill, n_held_fill;

    // stage one
    logic          r_s1_draw, n_s1_draw;
    logic          r_s1_tick, n_s1_tick;
    logic          r_s1_use_mem, n_s1_use_mem;
    logic [AW-1:0] r_s1_addr, n_s1_addr;
    logic [PW-1:0] r_s1_page, n_s1_page;
    logic [2:0]    r_s1_bit, n_s1_bit;
    logic          r_s1_on, n_s1_on;
    t_out_item     r_s1_out, n_s1_out;

    // write forwarding
    logic          r_fwd_vld;
    logic [AW-1:0] r_fwd_addr;
    logic [RW-1:0] r_fwd_row;

    // result register
    logic          r_out_strobe;
    t_out_item     r_out;

    logic          accept;
    logic          rd_en;
    logic [RW-1:0] rd_data;
    logic [RW-1:0] cur_row;
    logic [RW-1:0] new_row;
    logic          chip;
    logic [SW-1:0] step_idx;
    logic [8:0]    col;
    logic          draw_ok;
    t_out_item     out_now;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // draw coordinate check
    assign draw_ok = (i_item.x <= 8'(COLUMNS - 1)) && (i_item.y <= 8'(PAGES * 8 - 1));

    // write position within the current page
    always_comb begin
        chip     = (r_seq_step >= SW'(PER_CHIP));
        step_idx = chip ? (r_seq_step - SW'(PER_CHIP)) : r_seq_step;
        col      = (chip ? 9'(HALF_COLUMNS) : 9'd0) + 9'(step_idx) - 9'd2;
    end

    // decode and sequencer next state
    always_comb begin
        n_seq_active   = r_seq_active;
        n_seq_is_clear = r_seq_is_clear;
        n_seq_page     = r_seq_page;
        n_seq_step     = r_seq_step;
        n_held_fill    = r_held_fill;
        n_s1_draw      = 1'b0;
        n_s1_tick      = 1'b0;
        n_s1_use_mem   = 1'b0;
        n_s1_addr      = r_s1_addr;
        n_s1_page      = r_s1_page;
        n_s1_bit       = r_s1_bit;
        n_s1_on        = r_s1_on;
        n_s1_out       = r_s1_out;
        rd_en          = 1'b0;
        if (accept) begin
            unique case (i_item.func) inside
                FUNC_DRAW: begin
                    n_s1_draw = draw_ok;
                    rd_en     = draw_ok;
                    n_s1_addr = i_item.x[AW-1:0];
                    n_s1_page = PW'(i_item.y[7:3]);
                    n_s1_bit  = 3'd7 - i_item.y[2:0];
                    n_s1_on   = i_item.pixel_on;
                end
                FUNC_REFRESH, FUNC_CLEAR: begin
                    if (!r_seq_active) begin
                        n_seq_active   = 1'b1;
                        n_seq_is_clear = (i_item.func == FUNC_CLEAR);
                        n_seq_page     = '0;
                        n_seq_step     = '0;
                        n_held_fill    = i_item.fill_byte;
                    end
                end
                FUNC_TICK: begin
                    if (r_seq_active) begin
                        n_s1_tick           = 1'b1;
                        n_s1_out.right_chip = chip;
                        n_s1_out.is_data    = (step_idx >= SW'(2));
                        n_s1_out.last       = (r_seq_page == PW'(PAGES - 1)) &&
                                              (r_seq_step == SW'(PER_PAGE - 1));
                        n_s1_page           = r_seq_page;
                        n_s1_addr           = col[AW-1:0];
                        if (step_idx == SW'(0)) begin
                            n_s1_out.bus_byte = PAGE_CMD_BASE + 8'(r_seq_page);
                        end else if (step_idx == SW'(1)) begin
                            n_s1_out.bus_byte = COL_ZERO_CMD;
                        end else if (r_seq_is_clear) begin
                            n_s1_out.bus_byte = r_held_fill;
                        end else begin
                            // columns past the store send zero
                            n_s1_out.bus_byte = 8'h00;
                            n_s1_use_mem      = (col < 9'(COLUMNS));
                            rd_en             = (col < 9'(COLUMNS));
                        end
                        // advance step and page
                        if (r_seq_step >= SW'(PER_PAGE - 1)) begin
                            n_seq_step = '0;
                            if (r_seq_page >= PW'(PAGES - 1)) begin
                                n_seq_page   = '0;
                                n_seq_active = 1'b0;
                            end else begin
                                n_seq_page = r_seq_page + PW'(1);
                            end
                        end else begin
                            n_seq_step = r_seq_step + SW'(1);
                        end
                    end
                end
            endcase
        end
    end

    // frame store
    pflr_store #(
        .DEPTH (COLUMNS),
        .WIDTH (RW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (n_s1_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (r_s1_draw),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (new_row)
    );

    // stage one row with forwarding of last cycle's write, pixel update
    always_comb begin
        cur_row = (r_fwd_vld && (r_fwd_addr == r_s1_addr)) ? r_fwd_row : rd_data;
        new_row = cur_row;
        new_row[{r_s1_page, 3'b000} + (PW+3)'(r_s1_bit)] = r_s1_on;
        out_now = r_s1_out;
        if (r_s1_use_mem) begin
            out_now.bus_byte = cur_row[{r_s1_page, 3'b000} +: 8];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_active   <= 1'b0;
            r_seq_is_clear <= 1'b0;
            r_seq_page     <= '0;
            r_seq_step     <= '0;
            r_held_fill    <= '0;
            r_s1_draw      <= 1'b0;
            r_s1_tick      <= 1'b0;
            r_fwd_vld      <= 1'b0;
            r_out_strobe   <= 1'b0;
        end else begin
            r_seq_active   <= n_seq_active;
            r_seq_is_clear <= n_seq_is_clear;
            r_seq_page     <= n_seq_page;
            r_seq_step     <= n_seq_step;
            r_held_fill    <= n_held_fill;
            r_s1_draw      <= n_s1_draw;
            r_s1_tick      <= n_s1_tick;
            r_fwd_vld      <= r_s1_draw;
            r_out_strobe   <= r_s1_tick;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1_use_mem <= n_s1_use_mem;
        r_s1_addr    <= n_s1_addr;
        r_s1_page    <= n_s1_page;
        r_s1_bit     <= n_s1_bit;
        r_s1_on      <= n_s1_on;
        r_s1_out     <= n_s1_out;
        r_fwd_addr   <= r_s1_addr;
        r_fwd_row    <= new_row;
        r_out        <= out_now;
    end

    assign o_strobe = r_out_strobe;
    assign o_result = r_out;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page-mode LCD frame store refresher. It sends
// draw, refresh, clear and tick commands with random gaps, keeps its own
// copy of the frame store and sequencer, and compares every panel write
// against the predicted one.
// ----------------------------------------------------------------------------
module tb_top;
    import pflr_pkg::*;

    localparam int COLUMNS      = DEF_COLUMNS;
    localparam int PAGES        = DEF_PAGES;
    localparam int HALF_COLUMNS = DEF_HALF_COLUMNS;
    localparam int CHIP_WRITES  = HALF_COLUMNS + 2;
    localparam int PAGE_WRITES  = 2 * CHIP_WRITES;
    localparam int STORE_BYTES  = COLUMNS * PAGES;
    localparam int ROWS         = PAGES * 8;

    localparam int RANDOM_ITEMS = 1000;
    localparam int MAX_GAP      = 10;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SHOWN_LIMIT  = 10;

    // predicts panel writes from the transfers the block accepts
    class panel_write_model;
        logic [7:0]  pixel_bytes [STORE_BYTES];
        bit          running;
        bit          clearing;
        int unsigned page;
        int unsigned step;
        logic [7:0]  fill_hold;
        t_out_item   pending_writes [$];
        int unsigned mismatches;
        int unsigned writes_checked;
        int unsigned draws;
        int unsigned refreshes;
        int unsigned clears;
        int unsigned sequences_done;

        function void clear_state();
            foreach (pixel_bytes[i]) begin
                pixel_bytes[i] = 8'h00;
            end
            running        = 1'b0;
            clearing       = 1'b0;
            page           = 0;
            step           = 0;
            fill_hold      = 8'h00;
            mismatches     = 0;
            writes_checked = 0;
            draws          = 0;
            refreshes      = 0;
            clears         = 0;
            sequences_done = 0;
            pending_writes.delete();
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= SHOWN_LIMIT) begin
                $display("%0t mismatch: %s", $time, msg);
            end
        endfunction

        // update the store and sequencer for one accepted input transfer
        function void take_item(t_in_item it);
            int unsigned idx;
            int unsigned chip;
            int unsigned offset;
            int unsigned col;
            t_out_item   w;
            case (it.func) inside
                FUNC_DRAW: begin
                    draws++;
                    if (it.x <= COLUMNS - 1 && it.y <= ROWS - 1) begin
                        idx = it.x * PAGES + (it.y >> 3);
                        if (it.pixel_on) begin
                            pixel_bytes[idx] = pixel_bytes[idx] | (8'h80 >> it.y[2:0]);
                        end else begin
                            pixel_bytes[idx] = pixel_bytes[idx] & ~(8'h80 >> it.y[2:0]);
                        end
                    end
                end
                FUNC_REFRESH, FUNC_CLEAR: begin
                    // a start while a sequence runs is dropped
                    if (!running) begin
                        running   = 1'b1;
                        clearing  = (it.func == FUNC_CLEAR);
                        page      = 0;
                        step      = 0;
                        fill_hold = it.fill_byte;
                        if (clearing) begin
                            clears++;
                        end else begin
                            refreshes++;
                        end
                    end
                end
                FUNC_TICK: begin
                    if (running) begin
                        chip         = (step >= CHIP_WRITES) ? 1 : 0;
                        offset       = step - chip * CHIP_WRITES;
                        w.right_chip = chip[0];
                        if (offset == 0) begin
                            w.is_data  = 1'b0;
                            w.bus_byte = PAGE_CMD_BASE + page[7:0];
                        end else if (offset == 1) begin
                            w.is_data  = 1'b0;
                            w.bus_byte = COL_ZERO_CMD;
                        end else begin
                            w.is_data = 1'b1;
                            col       = chip * HALF_COLUMNS + offset - 2;
                            if (clearing) begin
                                w.bus_byte = fill_hold;
                            end else if (col < COLUMNS) begin
                                w.bus_byte = pixel_bytes[col * PAGES + page];
                            end else begin
                                w.bus_byte = 8'h00;
                            end
                        end
                        w.last = (page == PAGES - 1) && (step == PAGE_WRITES - 1);
                        pending_writes.push_back(w);

                        // advance through the page, then to the next page
                        if (step >= PAGE_WRITES - 1) begin
                            step = 0;
                            if (page >= PAGES - 1) begin
                                page    = 0;
                                running = 1'b0;
                                sequences_done++;
                            end else begin
                                page++;
                            end
                        end else begin
                            step++;
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // compare one strobed panel write against the oldest prediction
        function void check_write(t_out_item got);
            t_out_item want;
            if (pending_writes.size() == 0) begin
                flag($sformatf("unexpected write chip=%0d data=%0d byte=%02h last=%0d",
                    got.right_chip, got.is_data, got.bus_byte, got.last));
                return;
            end
            want = pending_writes.pop_front();
            writes_checked++;
            if (got.right_chip !== want.right_chip || got.is_data !== want.is_data ||
                    got.bus_byte !== want.bus_byte || got.last !== want.last) begin
                flag($sformatf({"write %0d expected chip=%0d data=%0d byte=%02h last=%0d,",
                    " got chip=%0d data=%0d byte=%02h last=%0d"},
                    writes_checked, want.right_chip, want.is_data, want.bus_byte,
                    want.last, got.right_chip, got.is_data, got.bus_byte, got.last));
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_start;
    logic      o_busy;
    t_in_item  i_item;
    logic      o_strobe;
    t_out_item o_result;

    panel_write_model model;
    bit               steady_run;
    int unsigned      items_sent;
    int unsigned      cycle_count;

    page_framebuffer_lcd_refresher_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
    end
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // watch both sides of the block
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                model.take_item(i_item);
            end
            if (o_strobe) begin
                model.check_write(o_result);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes outstanding",
                cycle_count, model.pending_writes.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_in_item make_item(t_func func, int x, int y, bit on, int fill);
        t_in_item it;
        it.func      = func;
        it.x         = x[7:0];
        it.y         = y[7:0];
        it.pixel_on  = on;
        it.fill_byte = fill[7:0];
        return it;
    endfunction

    function automatic t_in_item random_fields();
        t_in_item it;
        it.func      = t_func'($urandom_range(0, 3));
        it.x         = 8'($urandom_range(0, 255));
        it.y         = 8'($urandom_range(0, 255));
        it.pixel_on  = 1'($urandom_range(0, 1));
        it.fill_byte = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // one input transfer after a random gap
    task automatic send_item(t_in_item it);
        int unsigned gap;
        gap = steady_run ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
        // switch between gapped traffic and back-to-back stretches
        if ($urandom_range(0, 59) == 0) begin
            steady_run = !steady_run;
        end
    endtask

    initial begin
        t_in_item    it;
        int unsigned pick;
        int unsigned random_done;
        bit          ignored;

        model = new();
        model.clear_state();
        steady_run  = 1'b0;
        items_sent  = 0;
        cycle_count = 0;
        random_done = 0;

        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_item  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: corners, ignored draws, busy starts and idle ticks
        send_item(make_item(FUNC_TICK, 0, 0, 0, 0));
        send_item(make_item(FUNC_DRAW, 0, 0, 1, 0));
        send_item(make_item(FUNC_DRAW, COLUMNS - 1, ROWS - 1, 1, 0));
        send_item(make_item(FUNC_DRAW, COLUMNS, 0, 1, 0));
        send_item(make_item(FUNC_DRAW, 0, ROWS, 1, 255));
        send_item(make_item(FUNC_DRAW, 255, 255, 1, 255));
        send_item(make_item(FUNC_DRAW, HALF_COLUMNS - 1, 7, 1, 0));
        send_item(make_item(FUNC_DRAW, HALF_COLUMNS, 8, 1, 0));
        send_item(make_item(FUNC_DRAW, COLUMNS - 1, ROWS - 1, 0, 0));
        send_item(make_item(FUNC_DRAW, COLUMNS - 1, 24, 1, 0));
        send_item(make_item(FUNC_REFRESH, 0, 0, 0, 255));
        send_item(make_item(FUNC_CLEAR, 0, 0, 0, 8'hA5));
        send_item(make_item(FUNC_REFRESH, 0, 0, 0, 0));
        repeat (5) send_item(make_item(FUNC_TICK, 0, 0, 0, 0));
        send_item(make_item(FUNC_DRAW, 5, 0, 1, 0));
        repeat (5) send_item(make_item(FUNC_TICK, 255, 255, 1, 255));

        // random: mostly complete sequences with draws mixed in
        while (random_done < RANDOM_ITEMS || model.running) begin
            it   = random_fields();
            pick = $urandom_range(0, 99);
            if (model.running) begin
                if (pick < 84) begin
                    it.func = FUNC_TICK;
                end else if (pick < 94) begin
                    it.func = FUNC_DRAW;
                end else if (pick < 97) begin
                    it.func = FUNC_REFRESH;
                end else begin
                    it.func = FUNC_CLEAR;
                end
            end else begin
                if (pick < 95) begin
                    it.func = FUNC_DRAW;
                end else if (pick < 97) begin
                    it.func = FUNC_TICK;
                end else if (model.clears == 0 || $urandom_range(0, 2) == 0) begin
                    it.func = FUNC_CLEAR;
                end else begin
                    it.func = FUNC_REFRESH;
                end
            end
            if (it.func == FUNC_DRAW && $urandom_range(0, 9) != 0) begin
                it.x = 8'($urandom_range(0, COLUMNS - 1));
                it.y = 8'($urandom_range(0, ROWS - 1));
            end
            ignored = (it.func == FUNC_TICK && !model.running) ||
                      (it.func inside {FUNC_REFRESH, FUNC_CLEAR} && model.running) ||
                      (it.func == FUNC_DRAW && (it.x > COLUMNS - 1 || it.y > ROWS - 1));
            send_item(it);
            if (!ignored) begin
                random_done++;
            end
        end
        i_start <= 1'b0;

        // let every predicted write come out, then watch for strays
        while (model.pending_writes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d transfers: %0d draws, %0d refresh and %0d clear runs, %0d done",
            items_sent, model.draws, model.refreshes, model.clears, model.sequences_done);
        $display("checked %0d panel writes, %0d mismatches",
            model.writes_checked, model.mismatches);
        if (model.mismatches == 0 && model.pending_writes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
